// ----- src/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, ignored while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// same-cycle implication that also holds around reset
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/ptach_pkg.sv -----
// constants and shared types of the pulse tachometer
// no dependencies
package ptach_pkg;

  // event kinds
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  // field widths
  localparam int TIME_W  = 32;
  localparam int RPM_W   = 16;
  localparam int COUNT_W = 32;

  // rpm numerator, width chosen to hold it exactly
  localparam int NUM_W = 26;
  localparam logic [NUM_W-1:0] RPM_NUMERATOR = NUM_W'(60000000);
  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [TIME_W-1:0]  IDLE_INTERVAL = TIME_W'(100000000);
  localparam logic [TIME_W-1:0]  TIMEOUT_RESET = TIME_W'(500000);
  localparam logic [TIME_W-1:0]  EDGE_RESET    = TIME_W'(1);
  localparam logic [RPM_W-1:0]   RPM_MAX       = {RPM_W{1'b1}};

  // divider status toward the control logic
  typedef struct packed {
    logic             done;
    logic [RPM_W-1:0] rpm;
  } div_status_t;

endpackage

// ----- src/ptach_if.sv -----
// valid/ready channel interfaces for tach events and speed results
// depends on ptach_pkg
interface ptach_event_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ptach_pkg::TIME_W-1:0] now_us;

  modport source (output valid, output kind, output now_us, input ready);
  modport sink (input valid, input kind, input now_us, output ready);
endinterface

interface ptach_result_if;
  logic                          valid;
  logic                          ready;
  logic [ptach_pkg::RPM_W-1:0]   rpm;
  logic                          timed_out;
  logic [ptach_pkg::COUNT_W-1:0] pulse_count;

  modport source (output valid, output rpm, output timed_out, output pulse_count,
                  input ready);
  modport sink (input valid, input rpm, input timed_out, input pulse_count,
                output ready);
endinterface

// ----- src/ptach_div.sv -----
// bit-serial restoring divider: rpm numerator over the smoothed interval
// depends on ptach_pkg
module ptach_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ptach_pkg::TIME_W-1:0] divisor,
  output ptach_pkg::div_status_t       status
);

  logic                          busy;
  logic                          done;
  logic [ptach_pkg::CNT_W-1:0]   cnt;
  logic [ptach_pkg::NUM_W-1:0]   num;
  logic [ptach_pkg::NUM_W-1:0]   quo;
  logic [ptach_pkg::NUM_W-1:0]   rem;
  logic [ptach_pkg::TIME_W-1:0]  dvs;
  logic [ptach_pkg::NUM_W:0]     trial;
  logic                          fits;
  logic [ptach_pkg::NUM_W:0]     diff;
  logic [ptach_pkg::NUM_W-1:0]   rem_next;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem, num[ptach_pkg::NUM_W-1]};
    fits     = {{(ptach_pkg::TIME_W-ptach_pkg::NUM_W-1){1'b0}}, trial} >= dvs;
    diff     = trial - dvs[ptach_pkg::NUM_W:0];
    rem_next = fits ? diff[ptach_pkg::NUM_W-1:0] : trial[ptach_pkg::NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        num  <= ptach_pkg::RPM_NUMERATOR;
        rem  <= '0;
        quo  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        num <= {num[ptach_pkg::NUM_W-2:0], 1'b0};
        rem <= rem_next;
        quo <= {quo[ptach_pkg::NUM_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == ptach_pkg::CNT_W'(ptach_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate the quotient to the rpm range
  always_comb begin
    status.done = done;
    status.rpm  = (|quo[ptach_pkg::NUM_W-1:ptach_pkg::RPM_W]) ? ptach_pkg::RPM_MAX
                                                              : quo[ptach_pkg::RPM_W-1:0];
  end

endmodule

// ----- src/pulse_tachometer_rpm_core.sv -----
// period-based tachometer core: smoothed pulse interval to rpm
// depends on ptach_pkg, ptach_if and ptach_div
//
// usage:
//   tach carries timestamped events: kind edge (falling tach edge) or check
//   (timeout poll), each with a free-running microsecond time now_us.
//   speed returns one result per event: rpm, timed_out and pulse_count.
//   cfg_wr_en/cfg_wr_data write the timeout in us; write it only while idle.
// timing:
//   an edge with a nonzero smoothed interval runs a 26-step bit-serial divide
//   of 60000000 by that interval; a zero interval gives full-scale rpm with no
//   divide. every result, edge or check, passes S_FIN into the output register,
//   and the next event is taken once the core is back in S_IDLE.
//   the divider, one quotient bit per cycle, sets the edge rate while the
//   output register is free. one event is in work at a time; a new event is
//   taken while the previous result still waits in the output register.
// reset: rst is synchronous; timeout returns to 500000 us, interval to
//   100000000, rpm and pulse count to 0, last edge time to 1.
// stall: a finished result holds the core until the output register is free.
module pulse_tachometer_rpm_core (
  input  logic                         clk,
  input  logic                         rst,
  ptach_event_if.sink                  tach,
  ptach_result_if.source               speed,
  input  logic                         cfg_wr_en,
  input  logic [ptach_pkg::TIME_W-1:0] cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  state_t                        state;
  logic [ptach_pkg::TIME_W-1:0]  timeout;
  logic [ptach_pkg::TIME_W-1:0]  last_edge_time;
  logic [ptach_pkg::TIME_W-1:0]  interval;
  logic [ptach_pkg::RPM_W-1:0]   current_rpm;
  logic [ptach_pkg::COUNT_W-1:0] edge_total;
  logic                          flag;
  logic                          out_valid;
  logic [ptach_pkg::RPM_W-1:0]   out_rpm;
  logic                          out_timed_out;
  logic [ptach_pkg::COUNT_W-1:0] out_count;

  logic                          accept;
  logic                          is_edge;
  logic [ptach_pkg::TIME_W-1:0]  elapsed;
  logic [ptach_pkg::TIME_W-1:0]  interval_next;
  logic                          div_start;
  logic                          out_load;
  ptach_pkg::div_status_t        div_status;

  // event decode and interval smoothing
  always_comb begin
    accept        = tach.valid && tach.ready;
    is_edge       = tach.kind == ptach_pkg::KIND_EDGE;
    elapsed       = tach.now_us - last_edge_time;
    interval_next = (interval - (interval >> 2)) + (elapsed >> 2);
    div_start     = accept && is_edge && (interval_next != '0);
    out_load      = (state == S_FIN) && (!out_valid || speed.ready);
  end

  assign tach.ready        = state == S_IDLE;
  assign speed.valid       = out_valid;
  assign speed.rpm         = out_rpm;
  assign speed.timed_out   = out_timed_out;
  assign speed.pulse_count = out_count;

  ptach_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (interval_next),
    .status  (div_status)
  );

  // control, speed state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      timeout        <= ptach_pkg::TIMEOUT_RESET;
      last_edge_time <= ptach_pkg::EDGE_RESET;
      interval       <= ptach_pkg::IDLE_INTERVAL;
      current_rpm    <= '0;
      edge_total     <= '0;
      flag           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      // output register: load a finished result, else free it on a transfer
      if (out_load) begin
        out_valid     <= 1'b1;
        out_rpm       <= current_rpm;
        out_timed_out <= flag;
        out_count     <= edge_total;
      end else if (speed.valid && speed.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_edge) begin
              interval       <= interval_next;
              last_edge_time <= tach.now_us;
              edge_total     <= edge_total + 1'b1;
              flag           <= 1'b0;
              if (interval_next == '0) begin
                current_rpm <= ptach_pkg::RPM_MAX;
                state       <= S_FIN;
              end else begin
                state <= S_DIV;
              end
            end else begin
              if (elapsed > timeout) begin
                current_rpm <= '0;
                interval    <= ptach_pkg::IDLE_INTERVAL;
                flag        <= 1'b1;
              end else begin
                flag <= 1'b0;
              end
              state <= S_FIN;
            end
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            current_rpm <= div_status.rpm;
            state       <= S_FIN;
          end
        end
        S_FIN: begin
          // wait until the output register takes the result
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/ptach_checker.sv -----
// port-level checks of the tachometer core, bound into every instance of the core
// depends on assert_macros.svh and ptach_pkg
`include "assert_macros.svh"

module ptach_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ptach_pkg::RPM_W-1:0]   rpm,
  input logic                          timed_out,
  input logic [ptach_pkg::COUNT_W-1:0] pulse_count
);

  // a stalled result keeps its valid and payload
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(rpm) && $stable(timed_out) && $stable(pulse_count))

  // one event in work at a time: no transfer right after a transfer
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a timeout result always reports zero speed
  `ASSERT_IMP(a_timeout_zero, clk, rst, out_valid && timed_out, rpm == '0)

  // no result is offered right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid)

endmodule

bind pulse_tachometer_rpm_core ptach_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (tach.valid),
  .in_ready    (tach.ready),
  .out_valid   (speed.valid),
  .out_ready   (speed.ready),
  .rpm         (speed.rpm),
  .timed_out   (speed.timed_out),
  .pulse_count (speed.pulse_count)
);

// ----- sim/pulse_tachometer_rpm_core_tb.sv -----
// testbench for the pulse tachometer core: timestamped edges and timeout checks
// are driven in, and every speed result is compared with a cycle-free predictor
// depends on ptach_pkg, ptach_if and pulse_tachometer_rpm_core
module pulse_tachometer_rpm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PER_SETTING = 270;

  typedef struct packed {
    logic                         kind;
    logic [ptach_pkg::TIME_W-1:0] now_us;
  } tach_item_t;

  typedef struct packed {
    logic [ptach_pkg::RPM_W-1:0]   rpm;
    logic                          timed_out;
    logic [ptach_pkg::COUNT_W-1:0] pulse_count;
  } speed_rec_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [ptach_pkg::TIME_W-1:0] cfg_wr_data;

  ptach_event_if  tach_ch ();
  ptach_result_if speed_ch ();

  pulse_tachometer_rpm_core DUT (
    .clk         (clk),
    .rst         (rst),
    .tach        (tach_ch.sink),
    .speed       (speed_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // events waiting to be driven and speed results waiting to come back
  tach_item_t tach_events[$];
  speed_rec_t pending_speed[$];

  // predicted tachometer state
  logic [ptach_pkg::TIME_W-1:0]  est_timeout;
  logic [ptach_pkg::TIME_W-1:0]  est_last_edge;
  logic [ptach_pkg::TIME_W-1:0]  est_interval;
  logic [ptach_pkg::RPM_W-1:0]   est_rpm;
  logic [ptach_pkg::COUNT_W-1:0] est_pulses;

  // stimulus planning state
  logic [ptach_pkg::TIME_W-1:0] plan_last_edge;
  logic [ptach_pkg::TIME_W-1:0] plan_timeout;

  bit tach_took;
  bit calm;
  int send_gap;
  int hold_gap;
  int idle_cycles;
  int err_count;
  int n_edges;
  int n_checks;
  int n_timeouts;
  int n_saturated;
  int n_settings;

  // apply one event to the predicted state, return the speed it reports
  function automatic speed_rec_t advance_speed(logic kind,
                                               logic [ptach_pkg::TIME_W-1:0] now_us);
    logic [ptach_pkg::TIME_W-1:0] gap_us;
    logic [ptach_pkg::TIME_W-1:0] quot;
    speed_rec_t r;
    gap_us = now_us - est_last_edge;
    r.timed_out = 1'b0;
    if (kind == ptach_pkg::KIND_EDGE) begin
      est_interval = est_interval - (est_interval >> 2) + (gap_us >> 2);
      est_last_edge = now_us;
      if (est_interval == '0) begin
        est_rpm = ptach_pkg::RPM_MAX;
      end else begin
        quot = ptach_pkg::TIME_W'(ptach_pkg::RPM_NUMERATOR) / est_interval;
        est_rpm = (quot > ptach_pkg::TIME_W'(ptach_pkg::RPM_MAX)) ? ptach_pkg::RPM_MAX
                                                                  : quot[ptach_pkg::RPM_W-1:0];
      end
      est_pulses = est_pulses + 1'b1;
    end else if (gap_us > est_timeout) begin
      est_rpm = '0;
      est_interval = ptach_pkg::IDLE_INTERVAL;
      r.timed_out = 1'b1;
    end
    r.rpm = est_rpm;
    r.pulse_count = est_pulses;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  // queue one event for the driver and track the planned edge time
  task automatic add_event(logic kind, logic [ptach_pkg::TIME_W-1:0] stamp);
    tach_item_t it;
    it.kind = kind;
    it.now_us = stamp;
    tach_events.push_back(it);
    if (kind == ptach_pkg::KIND_EDGE) begin
      plan_last_edge = stamp;
    end
  endtask

  // timeout check, often right at the timeout boundary
  task automatic add_probe();
    logic [ptach_pkg::TIME_W-1:0] e;
    case ($urandom_range(0, 4))
      0: e = $urandom_range(0, 100);
      1: e = plan_timeout;
      2: e = plan_timeout + 1'b1;
      3: e = plan_timeout - 1'b1;
      default: e = $urandom;
    endcase
    add_event(ptach_pkg::KIND_CHECK, plan_last_edge + e);
  endtask

  // runs of edges at a steady period with random jitter and checks mixed in,
  // plus some unrelated events
  task automatic add_random(int count);
    int left;
    int run_len;
    logic [ptach_pkg::TIME_W-1:0] period;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        add_event(1'($urandom_range(0, 1)), $urandom);
        left--;
      end else begin
        case ($urandom_range(0, 3))
          0: period = $urandom_range(1, 915);
          1: period = $urandom_range(916, 60000);
          2: period = $urandom_range(60001, 100000000);
          default: period = $urandom;
        endcase
        run_len = $urandom_range(8, 60);
        for (int k = 0; k < run_len && left > 0; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            add_probe();
            left--;
          end
          add_event(ptach_pkg::KIND_EDGE,
                    plan_last_edge + period + $urandom_range(0, period >> 4));
          left--;
        end
        if ($urandom_range(0, 1) == 0) begin
          add_probe();
          left--;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (tach_events.size() != 0 || tach_ch.valid || pending_speed.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // write the timeout register once the core is idle
  task automatic set_timeout(logic [ptach_pkg::TIME_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    est_timeout = value;
    plan_timeout = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // event driver and result stalls, both change on the falling edge
  always @(negedge clk) begin : drive_side
    tach_item_t nxt;
    if (!rst) begin
      if (!tach_ch.valid || tach_took) begin
        if (calm) begin
          send_gap = 0;
        end else if (send_gap == 0 && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 18);
        end
        if (send_gap > 0 || tach_events.size() == 0) begin
          tach_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          nxt = tach_events.pop_front();
          tach_ch.valid <= 1'b1;
          tach_ch.kind <= nxt.kind;
          tach_ch.now_us <= nxt.now_us;
        end
      end
      if (calm) begin
        hold_gap = 0;
      end else if (hold_gap == 0 && $urandom_range(0, 11) == 0) begin
        hold_gap = $urandom_range(1, 18);
      end
      if (hold_gap > 0) begin
        speed_ch.ready <= 1'b0;
        hold_gap--;
      end else begin
        speed_ch.ready <= 1'b1;
      end
    end
  end

  // transfers on both channels, sampled on the rising edge
  always @(posedge clk) begin : speed_check
    speed_rec_t want;
    tach_took = 1'b0;
    if (!rst) begin
      // result side first: a result never belongs to an event taken this cycle
      if (speed_ch.valid && speed_ch.ready) begin
        if (pending_speed.size() == 0) begin
          report_mismatch("result with nothing pending, rpm", 32'(speed_ch.rpm), 32'd0);
        end else begin
          want = pending_speed.pop_front();
          if (speed_ch.rpm !== want.rpm)
            report_mismatch("rpm", 32'(speed_ch.rpm), 32'(want.rpm));
          if (speed_ch.timed_out !== want.timed_out)
            report_mismatch("timed_out", 32'(speed_ch.timed_out), 32'(want.timed_out));
          if (speed_ch.pulse_count !== want.pulse_count)
            report_mismatch("pulse_count", speed_ch.pulse_count, want.pulse_count);
          if (want.timed_out) n_timeouts++;
          if (want.rpm == ptach_pkg::RPM_MAX) n_saturated++;
        end
      end
      if (tach_ch.valid && tach_ch.ready) begin
        tach_took = 1'b1;
        pending_speed.push_back(advance_speed(tach_ch.kind, tach_ch.now_us));
        if (tach_ch.kind == ptach_pkg::KIND_EDGE) n_edges++;
        else n_checks++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (tach_ch.valid && tach_ch.ready) || (speed_ch.valid && speed_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("stalled for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    tach_ch.valid = 1'b0;
    tach_ch.kind = ptach_pkg::KIND_EDGE;
    tach_ch.now_us = '0;
    speed_ch.ready = 1'b0;
    calm = 1'b0;
    send_gap = 0;
    hold_gap = 0;
    idle_cycles = 0;
    err_count = 0;
    n_edges = 0;
    n_checks = 0;
    n_timeouts = 0;
    n_saturated = 0;
    n_settings = 1;
    est_timeout = ptach_pkg::TIMEOUT_RESET;
    est_last_edge = ptach_pkg::EDGE_RESET;
    est_interval = ptach_pkg::IDLE_INTERVAL;
    est_rpm = '0;
    est_pulses = '0;
    plan_timeout = ptach_pkg::TIMEOUT_RESET;
    plan_last_edge = ptach_pkg::EDGE_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: checks around the reset timeout, timestamp wrap, a fast run
    add_event(ptach_pkg::KIND_CHECK, 32'd1);
    add_event(ptach_pkg::KIND_CHECK, 32'd500001);
    add_event(ptach_pkg::KIND_CHECK, 32'd500002);
    add_event(ptach_pkg::KIND_CHECK, 32'd0);
    add_event(ptach_pkg::KIND_EDGE, 32'hFFFF_FFFF);
    add_event(ptach_pkg::KIND_EDGE, 32'd0);
    for (int k = 0; k < 12; k++) begin
      add_event(ptach_pkg::KIND_EDGE, plan_last_edge + 32'd100);
    end
    add_event(ptach_pkg::KIND_CHECK, plan_last_edge + 32'd50);
    add_event(ptach_pkg::KIND_CHECK, plan_last_edge + ptach_pkg::TIMEOUT_RESET + 32'd1);
    add_event(ptach_pkg::KIND_EDGE, plan_last_edge + 32'd60000);
    add_event(ptach_pkg::KIND_EDGE, 32'h8000_0000);
    add_random(RANDOM_PER_SETTING);

    // timeout extremes, zero, a random value, then the reset value with no stalls
    set_timeout(32'd1);
    add_random(RANDOM_PER_SETTING);
    set_timeout(32'hFFFF_FFFF);
    add_random(RANDOM_PER_SETTING);
    set_timeout(32'd0);
    add_random(RANDOM_PER_SETTING);
    set_timeout($urandom_range(1000, 3000000));
    add_random(RANDOM_PER_SETTING);
    set_timeout(ptach_pkg::TIMEOUT_RESET);
    calm = 1'b1;
    add_random(RANDOM_PER_SETTING);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d edges and %0d checks over %0d timeout settings",
             n_edges, n_checks, n_settings);
    $display("%0d results timed out, %0d saturated at full speed, %0d mismatches",
             n_timeouts, n_saturated, err_count);
    if (err_count == 0 && pending_speed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
